// File: sv/assert_macros.svh
// assertion macros used by the hvcc parser rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checks disabled while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checks disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/hcrp_pkg.sv
// shared types and constants for the hvcc configuration record parser
// no dependencies; imported by every module of the block
`default_nettype none

package hcrp_pkg;

    localparam int MAX_RESULTS     = 5;
    localparam int RUN_CNT_W       = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0]  PROF_IDC_MASK    = 8'h1F;
    localparam logic [7:0]  NAL_TYPE_MASK    = 8'h3F;
    localparam logic [7:0]  TWO_BIT_MASK     = 8'h03;
    localparam logic [7:0]  BIT_DEPTH_MASK   = 8'h07;
    localparam logic [15:0] MIN_SEG_MASK     = 16'h0FFF;
    localparam logic [3:0]  BIT_DEPTH_OFFSET = 4'd8;
    localparam logic [3:0]  LEN_SIZE_OFFSET  = 4'd1;

    localparam logic [2:0] NEED_COMPAT = 3'd4;
    localparam logic [2:0] NEED_CONSTR = 3'd6;
    localparam logic [2:0] NEED_SHORT  = 3'd2;

    typedef enum logic [4:0] {
        PH_VER,
        PH_PROF,
        PH_COMPAT,
        PH_CONSTR,
        PH_LEVEL,
        PH_MINSEG,
        PH_PAR,
        PH_CHROMA,
        PH_BDL,
        PH_BDC,
        PH_AFR,
        PH_FLAGS,
        PH_NARR,
        PH_ARRHDR,
        PH_NUNITS,
        PH_NALSIZE,
        PH_NALBYTE,
        PH_TRAIL
    } t_phase;

    typedef enum logic [4:0] {
        FC_VERSION        = 5'd0,
        FC_PROFILE_SPACE  = 5'd1,
        FC_TIER_FLAG      = 5'd2,
        FC_PROFILE_IDC    = 5'd3,
        FC_COMPAT_FLAGS   = 5'd4,
        FC_CONSTR_FLAGS   = 5'd5,
        FC_LEVEL_IDC      = 5'd6,
        FC_MIN_SEG_IDC    = 5'd7,
        FC_PARALLELISM    = 5'd8,
        FC_CHROMA_FORMAT  = 5'd9,
        FC_BIT_DEPTH_LUMA = 5'd10,
        FC_BIT_DEPTH_CHR  = 5'd11,
        FC_AVG_FRAME_RATE = 5'd12,
        FC_CONST_FR_RATE  = 5'd13,
        FC_NUM_TEMP_LAYER = 5'd14,
        FC_TEMP_ID_NESTED = 5'd15,
        FC_LENGTH_SIZE    = 5'd16,
        FC_ARRAY_COUNT    = 5'd17,
        FC_COMPLETENESS   = 5'd18,
        FC_NAL_TYPE       = 5'd19,
        FC_UNIT_COUNT     = 5'd20,
        FC_NAL_SIZE       = 5'd21,
        FC_NAL_BYTE       = 5'd22,
        FC_RECORD_END     = 5'd23
    } t_field_code;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [47:0] field_value;
        logic [7:0]  array_number;
        logic [15:0] unit_number;
    } t_result;

    // all results caused by one accepted byte, in order
    typedef struct packed {
        logic [RUN_CNT_W-1:0]         count;
        t_result [MAX_RESULTS-1:0]    slot;
    } t_run;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    function automatic t_result mk_result(t_field_code code, logic [47:0] value,
                                          logic [7:0] arr, logic [15:0] unit);
        t_result r;
        r.field_code   = code;
        r.field_value  = value;
        r.array_number = arr;
        r.unit_number  = unit;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/hcrp_if.sv
// byte input and result output channels of the hvcc parser
// no dependencies; valid/ready handshake with payload
`default_nettype none

interface hcrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       box_end;

    modport source (output valid, output byte_value, output box_end, input ready);
    modport sink   (input valid, input byte_value, input box_end, output ready);
endinterface

interface hcrp_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_code;
    logic [47:0] field_value;
    logic [7:0]  array_number;
    logic [15:0] unit_number;
    logic        last_of_run;

    modport source (output valid, output field_code, output field_value,
                    output array_number, output unit_number, output last_of_run,
                    input ready);
    modport sink   (input valid, input field_code, input field_value,
                    input array_number, input unit_number, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

// File: sv/hcrp_front.sv
// front end: accepts payload bytes, runs the parse state and builds result runs
// depends on hcrp_pkg and hcrp_in_if
`default_nettype none

module hcrp_front
    import hcrp_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    hcrp_in_if.sink            i_in,
    input  wire t_queue_status i_q_stat,
    output logic               o_push,
    output t_run               o_run
);

    t_phase      r_phase, n_phase;
    logic [47:0] r_acc, n_acc;
    logic [2:0]  r_nbytes, n_nbytes;
    logic [7:0]  r_arrays_left, n_arrays_left;
    logic [15:0] r_units_left, n_units_left;
    logic [15:0] r_payload_left, n_payload_left;
    logic [7:0]  r_array_idx, n_array_idx;
    logic [15:0] r_unit_idx, n_unit_idx;

    logic                        accept;
    logic [7:0]                  b;
    logic [47:0]                 acc_shift;
    logic [2:0]                  nbytes_inc;
    logic [2:0]                  need;
    logic                        field_done;
    logic                        is_gather;
    logic [7:0]                  ev_arr;
    logic [15:0]                 ev_unit;
    logic [7:0]                  arrays_dec;
    logic [15:0]                 units_dec;
    logic [15:0]                 payload_dec;
    logic [RUN_CNT_W-1:0]        np;
    t_result [MAX_RESULTS-1:0]   p_slot;
    t_result                     end_res;

    assign accept     = i_in.valid && !i_q_stat.full;
    assign i_in.ready = !i_q_stat.full;

    always_comb begin
        b           = i_in.byte_value;
        acc_shift   = {r_acc[39:0], b};
        nbytes_inc  = r_nbytes + 3'd1;
        arrays_dec  = r_arrays_left - 8'd1;
        units_dec   = r_units_left - 16'd1;
        payload_dec = r_payload_left - 16'd1;
        ev_arr      = (r_phase == PH_NARR) ? 8'd0 : r_array_idx;
        ev_unit     = (r_phase == PH_ARRHDR) ? 16'd0 : r_unit_idx;

        case (r_phase)
            PH_COMPAT: need = NEED_COMPAT;
            PH_CONSTR: need = NEED_CONSTR;
            default:   need = NEED_SHORT;
        endcase
        field_done = (nbytes_inc >= need);
        is_gather  = r_phase inside {PH_COMPAT, PH_CONSTR, PH_MINSEG, PH_AFR,
                                     PH_NUNITS, PH_NALSIZE};

        n_phase        = r_phase;
        n_acc          = r_acc;
        n_nbytes       = r_nbytes;
        n_arrays_left  = r_arrays_left;
        n_units_left   = r_units_left;
        n_payload_left = r_payload_left;
        n_array_idx    = r_array_idx;
        n_unit_idx     = r_unit_idx;
        np             = '0;
        p_slot         = '0;

        if (is_gather) begin
            n_acc    = field_done ? 48'd0 : acc_shift;
            n_nbytes = field_done ? 3'd0 : nbytes_inc;
        end

        case (r_phase)
            PH_VER: begin
                p_slot[0] = mk_result(FC_VERSION, 48'(b), ev_arr, ev_unit);
                np        = 3'd1;
                n_phase   = PH_PROF;
            end
            PH_PROF: begin
                p_slot[0] = mk_result(FC_PROFILE_SPACE, 48'(b[7:6]), ev_arr, ev_unit);
                p_slot[1] = mk_result(FC_TIER_FLAG, 48'(b[5]), ev_arr, ev_unit);
                p_slot[2] = mk_result(FC_PROFILE_IDC, 48'(b & PROF_IDC_MASK),
                                      ev_arr, ev_unit);
                np        = 3'd3;
                n_phase   = PH_COMPAT;
            end
            PH_COMPAT: begin
                if (field_done) begin
                    p_slot[0] = mk_result(FC_COMPAT_FLAGS, acc_shift, ev_arr, ev_unit);
                    np        = 3'd1;
                    n_phase   = PH_CONSTR;
                end
            end
            PH_CONSTR: begin
                if (field_done) begin
                    p_slot[0] = mk_result(FC_CONSTR_FLAGS, acc_shift, ev_arr, ev_unit);
                    np        = 3'd1;
                    n_phase   = PH_LEVEL;
                end
            end
            PH_LEVEL: begin
                p_slot[0] = mk_result(FC_LEVEL_IDC, 48'(b), ev_arr, ev_unit);
                np        = 3'd1;
                n_phase   = PH_MINSEG;
            end
            PH_MINSEG: begin
                if (field_done) begin
                    p_slot[0] = mk_result(FC_MIN_SEG_IDC, acc_shift & 48'(MIN_SEG_MASK),
                                          ev_arr, ev_unit);
                    np        = 3'd1;
                    n_phase   = PH_PAR;
                end
            end
            PH_PAR: begin
                p_slot[0] = mk_result(FC_PARALLELISM, 48'(b & TWO_BIT_MASK),
                                      ev_arr, ev_unit);
                np        = 3'd1;
                n_phase   = PH_CHROMA;
            end
            PH_CHROMA: begin
                p_slot[0] = mk_result(FC_CHROMA_FORMAT, 48'(b & TWO_BIT_MASK),
                                      ev_arr, ev_unit);
                np        = 3'd1;
                n_phase   = PH_BDL;
            end
            PH_BDL: begin
                p_slot[0] = mk_result(FC_BIT_DEPTH_LUMA,
                                      48'(b & BIT_DEPTH_MASK) + 48'(BIT_DEPTH_OFFSET),
                                      ev_arr, ev_unit);
                np        = 3'd1;
                n_phase   = PH_BDC;
            end
            PH_BDC: begin
                p_slot[0] = mk_result(FC_BIT_DEPTH_CHR,
                                      48'(b & BIT_DEPTH_MASK) + 48'(BIT_DEPTH_OFFSET),
                                      ev_arr, ev_unit);
                np        = 3'd1;
                n_phase   = PH_AFR;
            end
            PH_AFR: begin
                if (field_done) begin
                    p_slot[0] = mk_result(FC_AVG_FRAME_RATE, acc_shift, ev_arr, ev_unit);
                    np        = 3'd1;
                    n_phase   = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                p_slot[0] = mk_result(FC_CONST_FR_RATE, 48'(b[7:6]), ev_arr, ev_unit);
                p_slot[1] = mk_result(FC_NUM_TEMP_LAYER, 48'(b[5:3]), ev_arr, ev_unit);
                p_slot[2] = mk_result(FC_TEMP_ID_NESTED, 48'(b[2]), ev_arr, ev_unit);
                p_slot[3] = mk_result(FC_LENGTH_SIZE,
                                      48'(b & TWO_BIT_MASK) + 48'(LEN_SIZE_OFFSET),
                                      ev_arr, ev_unit);
                np        = 3'd4;
                n_phase   = PH_NARR;
            end
            PH_NARR: begin
                p_slot[0]     = mk_result(FC_ARRAY_COUNT, 48'(b), ev_arr, ev_unit);
                np            = 3'd1;
                n_arrays_left = b;
                n_array_idx   = 8'd0;
                n_phase       = (b != 8'd0) ? PH_ARRHDR : PH_TRAIL;
            end
            PH_ARRHDR: begin
                // completeness sits in the top bit of the header byte
                p_slot[0]  = mk_result(FC_COMPLETENESS, 48'(b[7]), ev_arr, ev_unit);
                p_slot[1]  = mk_result(FC_NAL_TYPE, 48'(b & NAL_TYPE_MASK),
                                       ev_arr, ev_unit);
                np         = 3'd2;
                n_unit_idx = 16'd0;
                n_phase    = PH_NUNITS;
            end
            PH_NUNITS: begin
                if (field_done) begin
                    p_slot[0]    = mk_result(FC_UNIT_COUNT, acc_shift, ev_arr, ev_unit);
                    np           = 3'd1;
                    n_units_left = acc_shift[15:0];
                    if (acc_shift[15:0] != 16'd0) begin
                        n_phase = PH_NALSIZE;
                    end else begin
                        n_array_idx   = r_array_idx + 8'd1;
                        n_arrays_left = arrays_dec;
                        n_phase       = (arrays_dec != 8'd0) ? PH_ARRHDR : PH_TRAIL;
                    end
                end
            end
            PH_NALSIZE: begin
                if (field_done) begin
                    if (acc_shift[15:0] == 16'd0) begin
                        // empty unit: no result, still counts against the unit count
                        n_units_left = units_dec;
                        if (units_dec != 16'd0) begin
                            n_phase = PH_NALSIZE;
                        end else begin
                            n_array_idx   = r_array_idx + 8'd1;
                            n_arrays_left = arrays_dec;
                            n_phase       = (arrays_dec != 8'd0) ? PH_ARRHDR : PH_TRAIL;
                        end
                    end else begin
                        p_slot[0]      = mk_result(FC_NAL_SIZE, acc_shift, ev_arr, ev_unit);
                        np             = 3'd1;
                        n_payload_left = acc_shift[15:0];
                        n_phase        = PH_NALBYTE;
                    end
                end
            end
            PH_NALBYTE: begin
                p_slot[0]      = mk_result(FC_NAL_BYTE, 48'(b), ev_arr, ev_unit);
                np             = 3'd1;
                n_payload_left = payload_dec;
                if (payload_dec == 16'd0) begin
                    n_unit_idx   = r_unit_idx + 16'd1;
                    n_units_left = units_dec;
                    if (units_dec != 16'd0) begin
                        n_phase = PH_NALSIZE;
                    end else begin
                        n_array_idx   = r_array_idx + 8'd1;
                        n_arrays_left = arrays_dec;
                        n_phase       = (arrays_dec != 8'd0) ? PH_ARRHDR : PH_TRAIL;
                    end
                end
            end
            default: begin
                // trailing bytes are dropped
            end
        endcase

        // record end carries the indices left by this byte, then all state clears
        end_res = mk_result(FC_RECORD_END, (n_phase == PH_TRAIL) ? 48'd0 : 48'd1,
                            n_array_idx, n_unit_idx);

        o_run.count = np + RUN_CNT_W'(i_in.box_end);
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (RUN_CNT_W'(k) < np) begin
                o_run.slot[k] = p_slot[k];
            end else if (RUN_CNT_W'(k) == np && i_in.box_end) begin
                o_run.slot[k] = end_res;
            end else begin
                o_run.slot[k] = '0;
            end
        end

        if (i_in.box_end) begin
            n_phase        = PH_VER;
            n_acc          = '0;
            n_nbytes       = '0;
            n_arrays_left  = '0;
            n_units_left   = '0;
            n_payload_left = '0;
            n_array_idx    = '0;
            n_unit_idx     = '0;
        end
    end

    assign o_push = accept && (o_run.count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_VER;
            r_acc          <= '0;
            r_nbytes       <= '0;
            r_arrays_left  <= '0;
            r_units_left   <= '0;
            r_payload_left <= '0;
            r_array_idx    <= '0;
            r_unit_idx     <= '0;
        end else if (accept) begin
            r_phase        <= n_phase;
            r_acc          <= n_acc;
            r_nbytes       <= n_nbytes;
            r_arrays_left  <= n_arrays_left;
            r_units_left   <= n_units_left;
            r_payload_left <= n_payload_left;
            r_array_idx    <= n_array_idx;
            r_unit_idx     <= n_unit_idx;
        end
    end

endmodule

`default_nettype wire

// File: sv/hcrp_queue.sv
// short fifo of result runs between front and back ends
// depends on hcrp_pkg
`default_nettype none

module hcrp_queue
    import hcrp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_run     i_run,
    input  wire logic     i_pop,
    output t_run          o_head,
    output t_queue_status o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_run             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

endmodule

`default_nettype wire

// File: sv/hcrp_back.sv
// back end: hands out the results of the head run one per request
// depends on hcrp_pkg and hcrp_out_if
`default_nettype none

module hcrp_back
    import hcrp_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_run          i_head,
    input  wire t_queue_status i_q_stat,
    output logic               o_pop,
    hcrp_out_if.source         o_out
);

    logic [RUN_CNT_W-1:0] r_slot;
    t_result              cur;
    logic                 last;
    logic                 take;

    assign cur  = i_head.slot[r_slot];
    assign last = (r_slot == i_head.count - RUN_CNT_W'(1));
    assign take = o_out.valid && o_out.ready;

    assign o_out.valid        = !i_q_stat.empty;
    assign o_out.field_code   = cur.field_code;
    assign o_out.field_value  = cur.field_value;
    assign o_out.array_number = cur.array_number;
    assign o_out.unit_number  = cur.unit_number;
    assign o_out.last_of_run  = last;

    // run leaves the queue with its final result
    assign o_pop = take && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (take) begin
            r_slot <= last ? '0 : r_slot + RUN_CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// File: sv/hevc_config_record_parser.sv
// Parses the payload of an hvcC box, one byte per request on i_in, and
// emits decoded header fields, array headers, unit counts, NAL sizes, NAL
// bytes and a record-end status on o_out, one result per cycle while o_out
// is ready. The front end takes a byte every cycle while the run queue has
// room; all parse state is updated in that single cycle, so bytes stream
// back to back. A byte yields zero to five results and the back end sends
// them likewise, so sustained input rate is one byte per cycle as long as
// bytes average at most one result; the header-flag bytes (four results)
// and the profile byte (three) hold the input for the extra output cycles
// once QUEUE_DEPTH runs are queued. After the last byte of a box the parser
// is back at its reset state and the next box may follow at once.
// depends on hcrp_pkg, hcrp_if, hcrp_front, hcrp_queue, hcrp_back
`default_nettype none
`include "assert_macros.svh"

module hevc_config_record_parser
    import hcrp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hcrp_in_if.sink     i_in,
    hcrp_out_if.source  o_out
);

    logic          w_push;
    logic          w_pop;
    t_run          w_run;
    t_run          w_head;
    t_queue_status w_q_stat;

    hcrp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_run    (w_run)
    );

    hcrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_run   (w_run),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    hcrp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    `ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, w_push, !w_q_stat.full, "run pushed into full queue")
    `ASSERT_IMPLIES(a_run_count, i_clk, i_rst_n, w_push, (w_run.count != '0) && (w_run.count <= RUN_CNT_W'(MAX_RESULTS)), "run count out of range")
    `ASSERT_IMPLIES(a_box_end_run, i_clk, i_rst_n, i_in.valid && i_in.ready && i_in.box_end, w_push, "box end byte produced no run")
    `ASSERT_IMPLIES(a_end_is_last, i_clk, i_rst_n, o_out.valid && (o_out.field_code == FC_RECORD_END), o_out.last_of_run, "record end not last of run")
    `ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, w_push && w_q_stat.empty, o_out.valid, "pushed run not presented")

endmodule

`default_nettype wire

// File: tb/sv/tb_hevc_config_record_parser.sv
// testbench for hevc_config_record_parser: directed rows, then random hvcC boxes
// byte requests are checked against an in-bench parser model, result by result
// depends on hcrp_pkg, hcrp_if and the parser rtl
`timescale 1ns / 1ps

module tb_hevc_config_record_parser;
    import hcrp_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 100;

    typedef struct {
        t_result res;
        logic    last;
    } t_field_rec;

    typedef struct {
        logic [7:0]  b;
        logic        e;
        bit          typed;
        t_field_code code;
        logic [47:0] value;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;

    hcrp_in_if  in_ch ();
    hcrp_out_if out_ch ();

    hevc_config_record_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // parser model state
    t_phase      phase;
    logic [47:0] acc;
    logic [2:0]  acc_bytes;
    logic [7:0]  arrays_due;
    logic [15:0] units_due;
    logic [15:0] nal_bytes_due;
    logic [7:0]  arr_idx;
    logic [15:0] unit_idx;

    t_field_rec  run_fields[$];
    t_field_rec  pending_fields[$];

    int          mismatches = 0;
    int          cycle_count = 0;

    // what the current request expects as its last result, for typed rows
    bit          row_typed = 1'b0;
    t_field_code row_code = FC_VERSION;
    logic [47:0] row_value = '0;

    // sender pacing and receiver hold-off
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    t_stim_row stim_rows [33] = '{
        '{8'h7F, 1'b1, 1'b1, FC_RECORD_END,     48'd1},     // one-byte box, truncated
        '{8'hFF, 1'b0, 1'b1, FC_VERSION,        48'hFF},
        '{8'hFF, 1'b0, 1'b0, FC_VERSION,        48'd0},     // profile byte
        '{8'h80, 1'b0, 1'b0, FC_VERSION,        48'd0},     // compat flags
        '{8'h00, 1'b0, 1'b0, FC_VERSION,        48'd0},
        '{8'h00, 1'b0, 1'b0, FC_VERSION,        48'd0},
        '{8'h01, 1'b0, 1'b0, FC_VERSION,        48'd0},
        '{8'hFF, 1'b0, 1'b0, FC_VERSION,        48'd0},     // constraint flags
        '{8'hFF, 1'b0, 1'b0, FC_VERSION,        48'd0},
        '{8'hFF, 1'b0, 1'b0, FC_VERSION,        48'd0},
        '{8'hFF, 1'b0, 1'b0, FC_VERSION,        48'd0},
        '{8'hFF, 1'b0, 1'b0, FC_VERSION,        48'd0},
        '{8'hFF, 1'b0, 1'b0, FC_VERSION,        48'd0},
        '{8'h00, 1'b0, 1'b1, FC_LEVEL_IDC,      48'd0},
        '{8'hFF, 1'b0, 1'b0, FC_VERSION,        48'd0},     // min segmentation
        '{8'hFF, 1'b0, 1'b1, FC_MIN_SEG_IDC,    48'hFFF},
        '{8'hFC, 1'b0, 1'b1, FC_PARALLELISM,    48'd0},
        '{8'hFF, 1'b0, 1'b1, FC_CHROMA_FORMAT,  48'd3},
        '{8'hFF, 1'b0, 1'b1, FC_BIT_DEPTH_LUMA, 48'd15},
        '{8'hF8, 1'b0, 1'b1, FC_BIT_DEPTH_CHR,  48'd8},
        '{8'hFF, 1'b0, 1'b0, FC_VERSION,        48'd0},     // average frame rate
        '{8'hFF, 1'b0, 1'b1, FC_AVG_FRAME_RATE, 48'hFFFF},
        '{8'hFF, 1'b0, 1'b1, FC_LENGTH_SIZE,    48'd4},
        '{8'h01, 1'b0, 1'b1, FC_ARRAY_COUNT,    48'd1},
        '{8'hBF, 1'b0, 1'b0, FC_VERSION,        48'd0},     // complete flag in bit 7 only
        '{8'h00, 1'b0, 1'b0, FC_VERSION,        48'd0},     // two units
        '{8'h02, 1'b0, 1'b1, FC_UNIT_COUNT,     48'd2},
        '{8'h00, 1'b0, 1'b0, FC_VERSION,        48'd0},     // empty nal unit
        '{8'h00, 1'b0, 1'b0, FC_VERSION,        48'd0},
        '{8'h00, 1'b0, 1'b0, FC_VERSION,        48'd0},     // one-byte nal unit
        '{8'h01, 1'b0, 1'b1, FC_NAL_SIZE,       48'd1},
        '{8'hA5, 1'b0, 1'b1, FC_NAL_BYTE,       48'hA5},
        '{8'h00, 1'b1, 1'b1, FC_RECORD_END,     48'd0}      // trailing byte closes the box
    };

    function automatic void clear_parser();
        phase         = PH_VER;
        acc           = '0;
        acc_bytes     = '0;
        arrays_due    = '0;
        units_due     = '0;
        nal_bytes_due = '0;
        arr_idx       = '0;
        unit_idx      = '0;
    endfunction

    function automatic void add_field(t_field_code code, logic [47:0] value);
        t_field_rec f;
        f.res.field_code   = code;
        f.res.field_value  = value;
        f.res.array_number = arr_idx;
        f.res.unit_number  = unit_idx;
        f.last             = 1'b0;
        run_fields = {run_fields, f};
    endfunction

    // big-endian gather; true once need bytes are in
    function automatic bit shift_in(logic [7:0] b, logic [2:0] need, output logic [47:0] word);
        acc       = {acc[39:0], b};
        acc_bytes = acc_bytes + 3'd1;
        word      = acc;
        if (acc_bytes >= need) begin
            acc       = '0;
            acc_bytes = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void next_array();
        arr_idx    = arr_idx + 8'd1;
        arrays_due = arrays_due - 8'd1;
        phase      = (arrays_due != 8'd0) ? PH_ARRHDR : PH_TRAIL;
    endfunction

    function automatic void next_unit();
        units_due = units_due - 16'd1;
        if (units_due != 16'd0) begin
            phase = PH_NALSIZE;
        end else begin
            next_array();
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic e);
        logic [47:0] w;
        run_fields.delete();
        case (phase)
            PH_VER: begin
                add_field(FC_VERSION, 48'(b));
                phase = PH_PROF;
            end
            PH_PROF: begin
                add_field(FC_PROFILE_SPACE, 48'(b[7:6]));
                add_field(FC_TIER_FLAG, 48'(b[5]));
                add_field(FC_PROFILE_IDC, 48'(b & PROF_IDC_MASK));
                phase = PH_COMPAT;
            end
            PH_COMPAT: begin
                if (shift_in(b, NEED_COMPAT, w)) begin
                    add_field(FC_COMPAT_FLAGS, w);
                    phase = PH_CONSTR;
                end
            end
            PH_CONSTR: begin
                if (shift_in(b, NEED_CONSTR, w)) begin
                    add_field(FC_CONSTR_FLAGS, w);
                    phase = PH_LEVEL;
                end
            end
            PH_LEVEL: begin
                add_field(FC_LEVEL_IDC, 48'(b));
                phase = PH_MINSEG;
            end
            PH_MINSEG: begin
                if (shift_in(b, NEED_SHORT, w)) begin
                    add_field(FC_MIN_SEG_IDC, 48'(w[15:0] & MIN_SEG_MASK));
                    phase = PH_PAR;
                end
            end
            PH_PAR: begin
                add_field(FC_PARALLELISM, 48'(b & TWO_BIT_MASK));
                phase = PH_CHROMA;
            end
            PH_CHROMA: begin
                add_field(FC_CHROMA_FORMAT, 48'(b & TWO_BIT_MASK));
                phase = PH_BDL;
            end
            PH_BDL: begin
                add_field(FC_BIT_DEPTH_LUMA, 48'(b & BIT_DEPTH_MASK) + 48'(BIT_DEPTH_OFFSET));
                phase = PH_BDC;
            end
            PH_BDC: begin
                add_field(FC_BIT_DEPTH_CHR, 48'(b & BIT_DEPTH_MASK) + 48'(BIT_DEPTH_OFFSET));
                phase = PH_AFR;
            end
            PH_AFR: begin
                if (shift_in(b, NEED_SHORT, w)) begin
                    add_field(FC_AVG_FRAME_RATE, w);
                    phase = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                add_field(FC_CONST_FR_RATE, 48'(b[7:6]));
                add_field(FC_NUM_TEMP_LAYER, 48'(b[5:3]));
                add_field(FC_TEMP_ID_NESTED, 48'(b[2]));
                add_field(FC_LENGTH_SIZE, 48'(b & TWO_BIT_MASK) + 48'(LEN_SIZE_OFFSET));
                phase = PH_NARR;
            end
            PH_NARR: begin
                add_field(FC_ARRAY_COUNT, 48'(b));
                arrays_due = b;
                arr_idx    = '0;
                phase      = (b != 8'd0) ? PH_ARRHDR : PH_TRAIL;
            end
            PH_ARRHDR: begin
                unit_idx = '0;
                add_field(FC_COMPLETENESS, 48'(b[7]));
                add_field(FC_NAL_TYPE, 48'(b & NAL_TYPE_MASK));
                phase = PH_NUNITS;
            end
            PH_NUNITS: begin
                if (shift_in(b, NEED_SHORT, w)) begin
                    units_due = w[15:0];
                    add_field(FC_UNIT_COUNT, w);
                    if (units_due != 16'd0) begin
                        phase = PH_NALSIZE;
                    end else begin
                        next_array();
                    end
                end
            end
            PH_NALSIZE: begin
                if (shift_in(b, NEED_SHORT, w)) begin
                    // an empty unit still uses up one of the declared count
                    if (w == 48'd0) begin
                        next_unit();
                    end else begin
                        add_field(FC_NAL_SIZE, w);
                        nal_bytes_due = w[15:0];
                        phase = PH_NALBYTE;
                    end
                end
            end
            PH_NALBYTE: begin
                add_field(FC_NAL_BYTE, 48'(b));
                nal_bytes_due = nal_bytes_due - 16'd1;
                if (nal_bytes_due == 16'd0) begin
                    unit_idx = unit_idx + 16'd1;
                    next_unit();
                end
            end
            default: begin
            end
        endcase
        if (e) begin
            add_field(FC_RECORD_END, (phase == PH_TRAIL) ? 48'd0 : 48'd1);
            clear_parser();
        end
        if (run_fields.size() > 0) begin
            run_fields[run_fields.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void compare_item(string what, logic [47:0] want, logic [47:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endfunction

    // scoreboard: requests in are decoded first, so a same-edge result can match
    always @(posedge clk) begin
        t_field_rec f;
        if (rst_n === 1'b1) begin
            if (in_ch.valid && in_ch.ready === 1'b1) begin
                decode_byte(in_ch.byte_value, in_ch.box_end);
                if (row_typed && run_fields.size() > 0) begin
                    run_fields[run_fields.size() - 1].res.field_code  = row_code;
                    run_fields[run_fields.size() - 1].res.field_value = row_value;
                end
                pending_fields = {pending_fields, run_fields};
            end
            if (out_ch.valid === 1'b1 && out_ch.ready) begin
                if (pending_fields.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got code %0d value 0x%0h",
                             $time, out_ch.field_code, out_ch.field_value);
                end else begin
                    f = pending_fields.pop_front();
                    compare_item("field_code", 48'(f.res.field_code), 48'(out_ch.field_code));
                    compare_item("field_value", f.res.field_value, out_ch.field_value);
                    compare_item("array_number", 48'(f.res.array_number),
                                 48'(out_ch.array_number));
                    compare_item("unit_number", 48'(f.res.unit_number), 48'(out_ch.unit_number));
                    compare_item("last_of_run", 48'(f.last), 48'(out_ch.last_of_run));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: own stall pattern, plus a long hold-off when asked
    initial begin
        int hold_left;
        int pat_mode;
        int pat_left;
        hold_left = 0;
        pat_mode  = 0;
        pat_left  = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(10, 60);
                end
                pat_left--;
                case (pat_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= ((pat_left % 4) != 0);
                endcase
            end
        end
    end

    // one byte request, after a random gap between bursts
    task automatic put_byte(logic [7:0] b, logic e, bit typed, t_field_code code,
                            logic [47:0] value);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= b;
        in_ch.box_end    <= e;
        row_typed = typed;
        row_code  = code;
        row_value = value;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_fields.size() != 0) @(posedge clk);
    endtask

    // random box: mostly well formed, some cut short, some with wide counts, some noise
    task automatic make_box(ref logic [7:0] box[$], ref int n_trail);
        int kind;
        int n_arr;
        int n_units;
        int nal_len;
        box.delete();
        n_trail = 0;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 8)) box = {box, 8'($urandom)};
            return;
        end
        repeat (22) box = {box, 8'($urandom)};
        if (kind == 1) begin
            // full-width array, unit and size counts, then the box stops early
            box = {box, 8'($urandom_range(1, 255))};
            repeat (5) box = {box, 8'($urandom)};
            repeat ($urandom_range(0, 6)) box = {box, 8'($urandom)};
            return;
        end
        n_arr = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
        box = {box, 8'(n_arr)};
        repeat (n_arr) begin
            box = {box, 8'($urandom)};
            n_units = $urandom_range(0, 3);
            box = {box, 8'h00};
            box = {box, 8'(n_units)};
            repeat (n_units) begin
                if ($urandom_range(0, 3) == 0) begin
                    nal_len = 0;
                end else begin
                    nal_len = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 4);
                end
                box = {box, 8'(nal_len >> 8)};
                box = {box, 8'(nal_len)};
                repeat (nal_len) box = {box, 8'($urandom)};
            end
        end
        if (kind == 2) begin
            repeat ($urandom_range(1, box.size() - 1)) void'(box.pop_back());
        end else begin
            n_trail = $urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0;
            repeat (n_trail) box = {box, 8'($urandom)};
        end
    endtask

    initial begin
        logic [7:0] box[$];
        int         n_trail;
        int         random_bytes;
        int         box_count;
        clear_parser();
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.byte_value = '0;
        in_ch.box_end    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            put_byte(stim_rows[k].b, stim_rows[k].e, stim_rows[k].typed,
                     stim_rows[k].code, stim_rows[k].value);
        end
        drain_results();

        random_bytes = 0;
        box_count    = 0;
        while (random_bytes < RANDOM_ITEMS) begin
            make_box(box, n_trail);
            if (box_count > 0 && $urandom_range(0, 3) == 0) drain_results();
            // output held off while requests keep coming
            if (box_count % 6 == 0) hold_req = 1'b1;
            foreach (box[k]) begin
                put_byte(box[k], k == box.size() - 1, 1'b0, FC_VERSION, '0);
            end
            random_bytes += box.size() - n_trail;
            box_count++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_fields.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/hcrp_pkg.sv
sv/hcrp_if.sv
sv/hcrp_front.sv
sv/hcrp_queue.sv
sv/hcrp_back.sv
sv/hevc_config_record_parser.sv
tb/sv/tb_hevc_config_record_parser.sv
